// ===== sv/lidf_pkg.sv =====
`timescale 1ns / 1ps

package lidf_pkg;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned CNT_W     = 4;

  // one result beat as it travels from the parser to the output stage
  typedef struct packed {
    logic [31:0] message_id;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        is_empty;
    logic        is_last;
  } res_t;

endpackage

// ===== sv/length_id_prefixed_deframer.sv =====
`timescale 1ns / 1ps

// Length/id prefixed message deframer.
// Input: one stream byte per beat on in_stream_byte; a beat is taken at a
// rising edge with in_push high and in_full low. Each message is an 8-byte
// header (32-bit little-endian payload length, then 32-bit little-endian
// message id) followed by the payload bytes.
// Output: one result beat per payload byte, carrying message id, length,
// the byte and is_last on the final byte. A zero-length message gives one
// beat with is_empty and is_last set and payload_byte zero. Header bytes
// give no result. A result is shown while out_empty is low and taken with
// out_pop.
// Throughput: one byte per cycle, sustained, while results drain.
// Path: with nothing waiting, the parser writes a taken byte's result into
// the queue, and the output register then loads it onto the out_ ports.
// Stall: a stalled receiver backs results up into the QDEPTH-entry queue
// plus the output register; in_full rises once the queue is full and holds
// every input byte, header bytes included, until space frees up.
// Reset: synchronous, active low; the parser expects a fresh header and
// both queue and output register come up empty.
module length_id_prefixed_deframer #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_stream_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_message_id,
  output logic [31:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_empty,
  output logic        out_is_last
);

  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic            in_acc;
  logic            f_vld;
  lidf_pkg::res_t  f_res;
  logic            q_full, q_empty, q_rd;
  logic [CW-1:0]   q_count;
  lidf_pkg::res_t  q_data;
  logic            b_vld;
  lidf_pkg::res_t  b_data;

  // hold all input while the queue has no room
  assign in_full = q_full;
  assign in_acc  = in_push && !q_full;

  // front: gather the header, classify each byte, emit result beats
  lidf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc),
    .byte_in  (in_stream_byte),
    .res_vld  (f_vld),
    .res      (f_res)
  );

  // decouple parser from the receiver
  lidf_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_vld),
    .wr_data (f_res),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty),
    .count   (q_count)
  );

  // back: registered result stage toward the receiver
  lidf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .pop      (out_pop),
    .out_vld  (b_vld),
    .out_data (b_data)
  );

  assign out_empty          = !b_vld;
  assign out_message_id     = b_data.message_id;
  assign out_payload_length = b_data.payload_length;
  assign out_payload_byte   = b_data.payload_byte;
  assign out_is_empty       = b_data.is_empty;
  assign out_is_last        = b_data.is_last;

  // queue fill never exceeds its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QDEPTH))
    else $error("queue count beyond depth");

  // an empty message is always the last beat, with a zero byte
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_empty) |-> (out_is_last && out_payload_byte == 8'd0))
    else $error("empty result not flagged last or byte nonzero");

  // a result never bypasses a full queue
  a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
    f_vld |-> !q_full)
    else $error("result produced while queue full");

  // output comes up empty after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("output not empty after reset");

endmodule

// ===== sv/lidf_front.sv =====
`timescale 1ns / 1ps

module lidf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       byte_in,
  output logic             res_vld,
  output lidf_pkg::res_t   res
);

  logic [lidf_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [63:0]                hdr_r, hdr_nxt;
  logic [31:0]                remain_r, remain_nxt;
  logic [63:0]                hdr_ins;

  // drop the new byte into its slot of the header
  always_comb begin
    hdr_ins = hdr_r;
    for (int k = 0; k < lidf_pkg::HDR_BYTES; k++) begin
      if (count_r == lidf_pkg::CNT_W'(k)) begin
        hdr_ins[8*k +: 8] = byte_in;
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    hdr_nxt    = hdr_r;
    remain_nxt = remain_r;
    res_vld    = 1'b0;
    res        = '0;
    res.message_id     = hdr_r[63:32];
    res.payload_length = hdr_r[31:0];
    res.payload_byte   = byte_in;
    if (byte_vld) begin
      if (count_r < lidf_pkg::CNT_W'(lidf_pkg::HDR_BYTES)) begin
        hdr_nxt   = hdr_ins;
        count_nxt = count_r + 1'b1;
        if (count_r == lidf_pkg::CNT_W'(lidf_pkg::HDR_BYTES - 1)) begin
          remain_nxt = hdr_ins[31:0];
          if (hdr_ins[31:0] == 32'd0) begin
            // empty message: one result, then back to header
            res_vld            = 1'b1;
            res.message_id     = hdr_ins[63:32];
            res.payload_length = hdr_ins[31:0];
            res.payload_byte   = 8'd0;
            res.is_empty       = 1'b1;
            res.is_last        = 1'b1;
            count_nxt          = '0;
          end
        end
      end else begin
        res_vld    = 1'b1;
        remain_nxt = remain_r - 32'd1;
        if (remain_r == 32'd1) begin
          res.is_last = 1'b1;
          count_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      remain_r <= '0;
    end else begin
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
    end
    hdr_r <= hdr_nxt;
  end

endmodule

// ===== sv/lidf_queue.sv =====
`timescale 1ns / 1ps

module lidf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  lidf_pkg::res_t               wr_data,
  input  logic                         rd_en,
  output lidf_pkg::res_t               rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lidf_pkg::res_t  mem [DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   count_r;
  logic            do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lidf_back.sv =====
`timescale 1ns / 1ps

module lidf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  lidf_pkg::res_t  q_data,
  output logic            q_rd,
  input  logic            pop,
  output logic            out_vld,
  output lidf_pkg::res_t  out_data
);

  logic           vld_r;
  lidf_pkg::res_t data_r;

  // refill the output register whenever it is free or being taken
  assign q_rd     = !q_empty && (!vld_r || pop);
  assign out_vld  = vld_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_rd) begin
      vld_r <= 1'b1;
    end else if (pop) begin
      vld_r <= 1'b0;
    end
    if (q_rd) begin
      data_r <= q_data;
    end
  end

endmodule
